FILE: hdl/ndd_pkg.sv
package ndd_pkg;

    localparam int DEF_MAX_POINTS    = 64;
    localparam int DEF_FRACTION_BITS = 16;

    localparam int POINTS_USED_W = 7;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_EVAL = 1'b1;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_REPEAT  = 2'd1;
    localparam logic [1:0] STATUS_NOPTS   = 2'd2;
    localparam logic [1:0] STATUS_DROPPED = 2'd3;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] x_value;
        logic signed [31:0] y_value;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0]             result_value;
        logic [1:0]                     status;
        logic [POINTS_USED_W-1:0]       points_used;
    } out_beat_t;

endpackage

FILE: hdl/newton_divided_difference_interp_core.sv
// An evaluate beat with n distinct points runs a scan of every pair of abscissas for a repeat,
// n * (n - 1) / 2 divisions on the bit-serial divider and n - 1 multiply steps on the
// bit-serial multiplier. One item is worked on at a time.
// Reset (aresetn, synchronous, active low) empties the point set and the output register;
// the point and coefficient memories are not cleared.
module newton_divided_difference_interp_core #(
    parameter int MAX_POINTS    = ndd_pkg::DEF_MAX_POINTS,
    parameter int FRACTION_BITS = ndd_pkg::DEF_FRACTION_BITS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ndd_pkg::in_beat_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ndd_pkg::out_beat_t m_data
);
    import ndd_pkg::*;

    // Count width holds MAX_POINTS itself; address width indexes the memories.
    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    // The dividend is a 48-bit magnitude followed by FRACTION_BITS zero bits.
    localparam int NW  = 48 + FRACTION_BITS;
    localparam int DCW = $clog2(NW + 1);
    // The multiplier walks the 33 bits of the difference magnitude.
    localparam int MB  = 33;
    localparam int MCW = $clog2(MB + 1);
    localparam int PW  = 48 + MB;

    localparam logic signed [48:0] LIM48_49 = 49'sh0_7FFF_FFFF_FFFF;

    typedef enum logic [3:0] {
        S_IDLE, S_DUP_RD, S_DUP_CMP, S_DD_RD, S_DD_SETUP, S_DD_DIV, S_DD_WR,
        S_EV_RD0, S_EV_LD, S_EV_RD, S_EV_SETUP, S_EV_MUL, S_EV_ADD, S_FIN
    } state_t;

    state_t state_reg;

    // Point and coefficient memories: one write port and two registered read ports each.
    logic signed [31:0] x_mem [MAX_POINTS];
    logic signed [47:0] c_mem [MAX_POINTS];
    logic signed [31:0] xr0_reg, xr1_reg;
    logic signed [47:0] cr0_reg, cr1_reg;

    logic [CW-1:0] cnt_reg;
    logic          ovf_reg;
    logic [CW-1:0] i_reg, j_reg, k_reg;
    logic [1:0]    status_reg;
    logic signed [31:0] q_reg;

    // Divider state.
    logic [NW-1:0]  dv_reg;
    logic [32:0]    ud_reg;
    logic [32:0]    rem_reg;
    logic [46:0]    quo_reg;
    logic           sticky_reg;
    logic [DCW-1:0] dcnt_reg;
    logic           neg_reg;

    // Multiplier and accumulator state.
    logic [47:0]    ua_reg;
    logic [48:0]    hi_reg;
    logic [MB-1:0]  lo_reg;
    logic [MCW-1:0] mcnt_reg;
    logic signed [47:0] acc_reg;
    logic signed [47:0] cadd_reg;

    logic      m_valid_reg;
    out_beat_t m_data_reg;

    // Memory access signals.
    logic [CW-1:0]      xa0, xa1, ca0, ca1;
    logic               xw_en, cw_en;
    logic [CW-1:0]      xw_addr, cw_addr;
    logic signed [47:0] cw_data;

    logic s_fire, load_fire, eval_fire, load_keep;

    // Datapath helpers.
    logic signed [48:0] dd_num;
    logic signed [32:0] dd_den;
    logic [48:0]        num_mag;
    logic [32:0]        den_mag;
    logic [33:0]        rem_try;
    logic [33:0]        rem_sub;
    logic               qbit;
    logic [46:0]        quo_mag;
    logic signed [47:0] quo_signed;

    logic signed [32:0] ev_diff;
    logic [32:0]        diff_mag;
    logic [47:0]        acc_mag;
    logic [48:0]        mul_sum;
    logic [PW-1:0]      product;
    logic [PW-1:0]      prod_shift;
    logic [46:0]        prod_mag;
    logic signed [47:0] prod_signed;
    logic signed [48:0] acc_sum;
    logic signed [47:0] acc_sat;
    logic signed [31:0] res32;
    logic [1:0]         fin_status;

    assign s_ready   = (state_reg == S_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign load_fire = s_fire && (s_data.mode == MODE_LOAD);
    assign eval_fire = s_fire && (s_data.mode == MODE_EVAL);
    assign load_keep = (cnt_reg < CW'(MAX_POINTS));

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Read addresses follow the state; outside the steps that read, they rest at zero.
    always_comb begin
        xa0 = '0;
        xa1 = '0;
        ca0 = '0;
        ca1 = '0;
        case (state_reg)
            S_DUP_RD: begin
                xa0 = i_reg;
                xa1 = j_reg;
            end
            S_DD_RD: begin
                ca0 = i_reg;
                ca1 = i_reg - CW'(1);
                xa0 = i_reg;
                xa1 = i_reg - k_reg;
            end
            S_EV_RD0: begin
                ca0 = cnt_reg - CW'(1);
            end
            S_EV_RD: begin
                xa0 = i_reg - CW'(1);
                ca0 = i_reg - CW'(1);
            end
            default: begin
                xa0 = '0;
            end
        endcase
    end

    // The coefficient memory is written by loads and by each finished division.
    always_comb begin
        xw_en   = load_fire && load_keep;
        xw_addr = cnt_reg;
        cw_en   = (load_fire && load_keep) || (state_reg == S_DD_WR);
        cw_addr = (state_reg == S_DD_WR) ? i_reg : cnt_reg;
        cw_data = (state_reg == S_DD_WR) ? quo_signed : 48'(s_data.y_value);
    end

    always_ff @(posedge aclk) begin
        if (xw_en) begin
            x_mem[xw_addr[AW-1:0]] <= s_data.x_value;
        end
        if (cw_en) begin
            c_mem[cw_addr[AW-1:0]] <= cw_data;
        end
        xr0_reg <= x_mem[xa0[AW-1:0]];
        xr1_reg <= x_mem[xa1[AW-1:0]];
        cr0_reg <= c_mem[ca0[AW-1:0]];
        cr1_reg <= c_mem[ca1[AW-1:0]];
    end

    // Divider: restoring, one quotient bit per cycle. A quotient bit pushed past bit 46
    // means the magnitude reached 2^47 and the result saturates.
    always_comb begin
        dd_num  = 49'(cr0_reg) - 49'(cr1_reg);
        dd_den  = 33'(xr0_reg) - 33'(xr1_reg);
        num_mag = dd_num[48] ? 49'(-dd_num) : 49'(dd_num);
        den_mag = dd_den[32] ? 33'(-dd_den) : 33'(dd_den);
        rem_try = {rem_reg, dv_reg[NW-1]};
        rem_sub = rem_try - {1'b0, ud_reg};
        qbit    = (rem_try >= {1'b0, ud_reg});
        quo_mag = sticky_reg ? '1 : quo_reg;
        quo_signed = neg_reg ? -$signed({1'b0, quo_mag}) : $signed({1'b0, quo_mag});
    end

    // Multiplier: shift-and-add over the difference bits, then truncate, saturate,
    // add the next coefficient and saturate again.
    always_comb begin
        ev_diff  = 33'(q_reg) - 33'(xr0_reg);
        diff_mag = ev_diff[32] ? 33'(-ev_diff) : 33'(ev_diff);
        acc_mag  = acc_reg[47] ? 48'(-acc_reg) : 48'(acc_reg);
        mul_sum  = hi_reg + (lo_reg[0] ? {1'b0, ua_reg} : 49'd0);
        product  = {hi_reg[47:0], lo_reg};
        prod_shift = product >> FRACTION_BITS;
        prod_mag = (|prod_shift[PW-1:47]) ? '1 : prod_shift[46:0];
        prod_signed = neg_reg ? -$signed({1'b0, prod_mag}) : $signed({1'b0, prod_mag});
        acc_sum  = 49'(prod_signed) + 49'(cadd_reg);
        if (acc_sum > LIM48_49) begin
            acc_sat = 48'(LIM48_49);
        end else if (acc_sum < -LIM48_49) begin
            acc_sat = 48'(-LIM48_49);
        end else begin
            acc_sat = acc_sum[47:0];
        end
    end

    // Output value and status for the finishing evaluate.
    always_comb begin
        if (acc_reg > 48'sd2147483647) begin
            res32 = 32'sh7FFF_FFFF;
        end else if (acc_reg < -48'sd2147483648) begin
            res32 = 32'sh8000_0000;
        end else begin
            res32 = acc_reg[31:0];
        end
        fin_status = ((status_reg == STATUS_OK) && ovf_reg) ? STATUS_DROPPED : status_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            // In S_FIN a taken beat is always replaced by the new result below.
            if (m_valid_reg && m_ready && (state_reg != S_FIN)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (load_fire) begin
                        if (load_keep) begin
                            cnt_reg <= cnt_reg + CW'(1);
                        end else begin
                            ovf_reg <= 1'b1;
                        end
                    end else if (eval_fire) begin
                        q_reg      <= s_data.x_value;
                        status_reg <= STATUS_OK;
                        acc_reg    <= '0;
                        i_reg      <= '0;
                        j_reg      <= CW'(1);
                        if (cnt_reg == '0) begin
                            status_reg <= STATUS_NOPTS;
                            state_reg  <= S_FIN;
                        end else if (cnt_reg == CW'(1)) begin
                            state_reg <= S_EV_RD0;
                        end else begin
                            state_reg <= S_DUP_RD;
                        end
                    end
                end
                // Scan every pair of loaded abscissas for a repeat.
                S_DUP_RD: begin
                    state_reg <= S_DUP_CMP;
                end
                S_DUP_CMP: begin
                    if (xr0_reg == xr1_reg) begin
                        status_reg <= STATUS_REPEAT;
                        state_reg  <= S_FIN;
                    end else if (j_reg == cnt_reg - CW'(1)) begin
                        if (i_reg + CW'(2) == cnt_reg) begin
                            k_reg     <= CW'(1);
                            i_reg     <= cnt_reg - CW'(1);
                            state_reg <= S_DD_RD;
                        end else begin
                            i_reg     <= i_reg + CW'(1);
                            j_reg     <= i_reg + CW'(2);
                            state_reg <= S_DUP_RD;
                        end
                    end else begin
                        j_reg     <= j_reg + CW'(1);
                        state_reg <= S_DUP_RD;
                    end
                end
                // Divided differences, level k, from the top entry down to entry k.
                S_DD_RD: begin
                    state_reg <= S_DD_SETUP;
                end
                S_DD_SETUP: begin
                    neg_reg    <= dd_num[48] ^ dd_den[32];
                    dv_reg     <= {num_mag[47:0], {FRACTION_BITS{1'b0}}};
                    ud_reg     <= den_mag;
                    rem_reg    <= '0;
                    quo_reg    <= '0;
                    sticky_reg <= 1'b0;
                    dcnt_reg   <= DCW'(NW);
                    state_reg  <= S_DD_DIV;
                end
                S_DD_DIV: begin
                    rem_reg    <= qbit ? rem_sub[32:0] : rem_try[32:0];
                    quo_reg    <= {quo_reg[45:0], qbit};
                    sticky_reg <= sticky_reg | quo_reg[46];
                    dv_reg     <= {dv_reg[NW-2:0], 1'b0};
                    dcnt_reg   <= dcnt_reg - DCW'(1);
                    if (dcnt_reg == DCW'(1)) begin
                        state_reg <= S_DD_WR;
                    end
                end
                S_DD_WR: begin
                    if (i_reg == k_reg) begin
                        if (k_reg == cnt_reg - CW'(1)) begin
                            state_reg <= S_EV_RD0;
                        end else begin
                            k_reg     <= k_reg + CW'(1);
                            i_reg     <= cnt_reg - CW'(1);
                            state_reg <= S_DD_RD;
                        end
                    end else begin
                        i_reg     <= i_reg - CW'(1);
                        state_reg <= S_DD_RD;
                    end
                end
                // Nested evaluation, starting from the top coefficient.
                S_EV_RD0: begin
                    state_reg <= S_EV_LD;
                end
                S_EV_LD: begin
                    acc_reg <= cr0_reg;
                    i_reg   <= cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1)) begin
                        state_reg <= S_FIN;
                    end else begin
                        state_reg <= S_EV_RD;
                    end
                end
                S_EV_RD: begin
                    state_reg <= S_EV_SETUP;
                end
                S_EV_SETUP: begin
                    neg_reg   <= acc_reg[47] ^ ev_diff[32];
                    ua_reg    <= acc_mag;
                    hi_reg    <= '0;
                    lo_reg    <= diff_mag;
                    mcnt_reg  <= MCW'(MB);
                    cadd_reg  <= cr0_reg;
                    state_reg <= S_EV_MUL;
                end
                S_EV_MUL: begin
                    hi_reg   <= {1'b0, mul_sum[48:1]};
                    lo_reg   <= {mul_sum[0], lo_reg[MB-1:1]};
                    mcnt_reg <= mcnt_reg - MCW'(1);
                    if (mcnt_reg == MCW'(1)) begin
                        state_reg <= S_EV_ADD;
                    end
                end
                S_EV_ADD: begin
                    acc_reg <= acc_sat;
                    i_reg   <= i_reg - CW'(1);
                    if (i_reg == CW'(1)) begin
                        state_reg <= S_FIN;
                    end else begin
                        state_reg <= S_EV_RD;
                    end
                end
                // Hand the result to the output register once it is free, then
                // empty the point set.
                S_FIN: begin
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg.result_value <= (status_reg == STATUS_OK) ? res32 : '0;
                        m_data_reg.status       <= fin_status;
                        m_data_reg.points_used  <= POINTS_USED_W'(cnt_reg);
                        m_valid_reg <= 1'b1;
                        cnt_reg     <= '0;
                        ovf_reg     <= 1'b0;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: tb/newton_divided_difference_interp_core_tb.sv
`timescale 1ns / 1ps

module newton_divided_difference_interp_core_tb;
    import ndd_pkg::*;

    localparam int  N_POINTS   = DEF_MAX_POINTS;
    localparam int  FRAC       = DEF_FRACTION_BITS;
    localparam longint LIM48   = 64'sh7FFF_FFFF_FFFF;
    // The slowest run holds one full set of 64 distinct abscissas plus a few dozen
    // small sets; the limit is that run length taken many times over.
    localparam int  CYCLE_LIMIT = 3_000_000;
    localparam int  LONG_HOLD   = 400;

    // One stimulus row: the beat, and optionally a result typed in by hand.
    typedef struct {
        in_beat_t  beat;
        bit        typed;
        out_beat_t want;
    } stim_row_t;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_beat_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_beat_t m_data;

    stim_row_t stim_rows[$];
    out_beat_t pending_results[$];
    int        beats_taken;
    int        results_seen;
    int        mismatches;
    int        cycle_count;
    bit        stim_done;

    // Predictor state: the loaded point set.
    longint    pt_x[N_POINTS];
    longint    pt_c[N_POINTS];
    int        pt_count;
    bit        pt_dropped;

    newton_divided_difference_interp_core i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------------
    // Fixed-point helpers for the divided-difference predictor.
    // ---------------------------------------------------------------------
    function automatic longint clamp48(longint v);
        if (v > LIM48) return LIM48;
        if (v < -LIM48) return -LIM48;
        return v;
    endfunction

    function automatic longint abs64(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // (a * b) >> FRAC, truncated toward zero and saturated. The product is
    // split at bit 24 of a so that nothing overflows 64 bits.
    function automatic longint scaled_product(longint a, longint b);
        bit neg;
        longint unsigned ua, ub, hi, lo, m;
        neg = (a < 0) != (b < 0);
        ua  = abs64(a);
        ub  = abs64(b);
        hi  = (ua >> 24) * ub;
        lo  = (ua & 64'hFF_FFFF) * ub;
        if (hi > (longint'(LIM48) >> (24 - FRAC))) begin
            m = LIM48;
        end else begin
            m = (hi << (24 - FRAC)) + (lo >> FRAC);
            if (m > LIM48) m = LIM48;
        end
        return neg ? -longint'(m) : longint'(m);
    endfunction

    // (num << FRAC) / den by restoring long division, saturated.
    function automatic longint scaled_quotient(longint num, longint den);
        bit neg, sat;
        longint unsigned un, ud, q, r;
        neg = (num < 0) != (den < 0);
        un  = abs64(num);
        ud  = abs64(den);
        q   = un / ud;
        r   = un % ud;
        sat = q > LIM48;
        for (int k = 0; k < FRAC && !sat; k++) begin
            r = r << 1;
            q = q << 1;
            if (r >= ud) begin
                r = r - ud;
                q = q | 1;
            end
            if (q > LIM48) sat = 1'b1;
        end
        if (sat) q = LIM48;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    // Applies one accepted beat to the point set. Returns 1 and the value
    // when the beat is an evaluate.
    function automatic bit interpolate_beat(in_beat_t b, output out_beat_t r);
        int        n;
        longint    q, acc;
        logic [1:0] st;
        n   = pt_count;
        q   = longint'(b.x_value);
        acc = 0;
        st  = STATUS_OK;
        r   = '0;
        if (b.mode == MODE_LOAD) begin
            if (n < N_POINTS) begin
                pt_x[n]  = longint'(b.x_value);
                pt_c[n]  = longint'(b.y_value);
                pt_count = n + 1;
            end else begin
                pt_dropped = 1'b1;
            end
            return 1'b0;
        end
        if (n == 0) begin
            st = STATUS_NOPTS;
        end else begin
            for (int i = 0; i < n && st == STATUS_OK; i++)
                for (int j = i + 1; j < n; j++)
                    if (pt_x[i] == pt_x[j]) st = STATUS_REPEAT;
        end
        if (st == STATUS_OK) begin
            // Build the coefficients in place, highest index first per level.
            for (int k = 1; k < n; k++)
                for (int i = n - 1; i >= k; i--)
                    pt_c[i] = scaled_quotient(pt_c[i] - pt_c[i-1], pt_x[i] - pt_x[i-k]);
            acc = pt_c[n-1];
            for (int i = n - 1; i > 0; i--)
                acc = clamp48(scaled_product(acc, q - pt_x[i-1]) + pt_c[i-1]);
            if (pt_dropped) st = STATUS_DROPPED;
        end
        if (acc > 64'sd2147483647) acc = 64'sd2147483647;
        if (acc < -64'sd2147483648) acc = -64'sd2147483648;
        r.result_value = acc[31:0];
        r.status       = st;
        r.points_used  = n[POINTS_USED_W-1:0];
        pt_count       = 0;
        pt_dropped     = 1'b0;
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------------
    // Stimulus construction.
    // ---------------------------------------------------------------------
    function automatic stim_row_t mk_row(logic mode, logic [31:0] x, logic [31:0] y,
                                         bit typed = 0, logic [31:0] v = 0,
                                         logic [1:0] st = STATUS_OK, int pu = 0);
        stim_row_t row;
        row.beat.mode    = mode;
        row.beat.x_value = x;
        row.beat.y_value = y;
        row.typed        = typed;
        row.want.result_value = v;
        row.want.status       = st;
        row.want.points_used  = pu[POINTS_USED_W-1:0];
        return row;
    endfunction

    // A random abscissa: mostly small so the polynomial stays in range,
    // sometimes the full 32-bit range so every bit toggles.
    function automatic logic [31:0] rand_coord();
        if ($urandom_range(0, 3) == 0) return $urandom;
        return $urandom_range(0, 32 << FRAC) - (16 << FRAC);
    endfunction

    task automatic build_stimulus();
        stim_row_t   directed[$];
        logic [31:0] xs[$];
        logic [31:0] x;
        int          n;
        bit          clash;

        // Directed table: empty set, single point at the extremes, a repeated
        // abscissa, extreme points and an exact quadratic (y = x^2 at 3 is 9).
        directed.push_back(mk_row(MODE_EVAL, 0, 0, 1, 0, STATUS_NOPTS, 0));
        directed.push_back(mk_row(MODE_LOAD, 32'h0001_0000, 32'h7FFF_FFFF));
        directed.push_back(mk_row(MODE_EVAL, 32'h8000_0000, 0, 1, 32'h7FFF_FFFF,
                                  STATUS_OK, 1));
        directed.push_back(mk_row(MODE_LOAD, 5 << FRAC, 1));
        directed.push_back(mk_row(MODE_LOAD, 5 << FRAC, 2));
        directed.push_back(mk_row(MODE_EVAL, 0, 32'hFFFF_FFFF, 1, 0, STATUS_REPEAT, 2));
        directed.push_back(mk_row(MODE_LOAD, 32'h8000_0000, 32'h8000_0000));
        directed.push_back(mk_row(MODE_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        directed.push_back(mk_row(MODE_EVAL, 0, 0));
        directed.push_back(mk_row(MODE_LOAD, 32'h8000_0000, 32'h7FFF_FFFF));
        directed.push_back(mk_row(MODE_LOAD, 32'h7FFF_FFFF, 32'h8000_0000));
        directed.push_back(mk_row(MODE_EVAL, 32'h7FFF_FFFF, 0));
        directed.push_back(mk_row(MODE_LOAD, 0, 0));
        directed.push_back(mk_row(MODE_LOAD, 1 << FRAC, 1 << FRAC));
        directed.push_back(mk_row(MODE_LOAD, 2 << FRAC, 4 << FRAC));
        directed.push_back(mk_row(MODE_EVAL, 3 << FRAC, 0, 1, 9 << FRAC, STATUS_OK, 3));
        directed.push_back(mk_row(MODE_EVAL, 32'h8000_0000, 0, 1, 0, STATUS_NOPTS, 0));
        foreach (directed[i]) stim_rows.push_back(directed[i]);

        // A full set with all abscissas equal plus a dropped point: the
        // repeat outranks the dropped flag, and the scan stops early.
        for (int i = 0; i <= N_POINTS; i++)
            stim_rows.push_back(mk_row(MODE_LOAD, 32'h0000_1234, i));
        stim_rows.push_back(mk_row(MODE_EVAL, 0, 0, 1, 0, STATUS_REPEAT, N_POINTS));

        // A full set of distinct points on y = 0 plus a dropped point.
        for (int i = 0; i <= N_POINTS; i++)
            stim_rows.push_back(mk_row(MODE_LOAD, i << FRAC, 0));
        stim_rows.push_back(mk_row(MODE_EVAL, 7 << FRAC, 0, 1, 0, STATUS_DROPPED,
                                   N_POINTS));

        // Random part: mostly small well-formed sets, some noise evaluates.
        while (stim_rows.size() < 290) begin
            if ($urandom_range(0, 9) == 0) begin
                stim_rows.push_back(mk_row(MODE_EVAL, $urandom, $urandom));
            end else begin
                n = $urandom_range(1, 8);
                xs.delete();
                for (int i = 0; i < n; i++) begin
                    if (i > 0 && $urandom_range(0, 19) == 0) begin
                        x = xs[$urandom_range(0, i - 1)];
                    end else begin
                        do begin
                            x = rand_coord();
                            clash = 0;
                            foreach (xs[j]) if (xs[j] == x) clash = 1;
                        end while (clash);
                    end
                    xs.push_back(x);
                    stim_rows.push_back(mk_row(MODE_LOAD, x,
                        ($urandom_range(0, 2) == 0) ? $urandom : rand_coord()));
                end
                stim_rows.push_back(mk_row(MODE_EVAL, rand_coord(), $urandom));
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // Sender: one beat per row, back to back for the first 20 rows of every 60, else after a random gap.
    // ---------------------------------------------------------------------
    initial begin
        int gap;
        s_valid   = 1'b0;
        s_data    = '0;
        aresetn   = 1'b0;
        stim_done = 1'b0;
        build_stimulus();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        foreach (stim_rows[i]) begin
            gap = (i % 60 < 20) ? 0 : $urandom_range(0, 7);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            @(negedge aclk);
            s_valid <= 1'b1;
            s_data  <= stim_rows[i].beat;
            do @(posedge aclk); while (!s_ready);
        end
        @(negedge aclk);
        s_valid   <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver: random stalls per result, and once a long hold-off so the
    // block fills up and pushes back on the sender.
    initial begin
        int stall;
        int held;
        m_ready = 1'b0;
        @(posedge aresetn);
        held = 0;
        forever begin
            stall = (results_seen % 40 < 10) ? 0 : $urandom_range(0, 7);
            if (results_seen == 12 && held == 0) begin
                stall = LONG_HOLD;
                held  = 1;
            end
            if (stall > 0) begin
                @(negedge aclk);
                m_ready <= 1'b0;
                for (int c = 1; c < stall; c++) @(negedge aclk);
            end
            @(negedge aclk);
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    // Input monitor: every accepted beat goes through the predictor. A
    // hand-typed result, where the row has one, replaces the predicted one.
    always @(posedge aclk) begin
        out_beat_t r;
        if (aresetn && s_valid && s_ready) begin
            if (interpolate_beat(s_data, r))
                pending_results.push_back(stim_rows[beats_taken].typed ?
                                          stim_rows[beats_taken].want : r);
            beats_taken <= beats_taken + 1;
        end
    end

    // Output checker: each result beat against the oldest expectation.
    always @(posedge aclk) begin
        out_beat_t w;
        if (aresetn && m_valid && m_ready) begin
            results_seen <= results_seen + 1;
            if (pending_results.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("unexpected result beat: value %h status %0d points %0d",
                             m_data.result_value, m_data.status, m_data.points_used);
            end else begin
                w = pending_results.pop_front();
                if (m_data.result_value !== w.result_value || m_data.status !== w.status ||
                    m_data.points_used !== w.points_used) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("result %0d: want %h/%0d/%0d got %h/%0d/%0d",
                                 results_seen, w.result_value, w.status, w.points_used,
                                 m_data.result_value, m_data.status, m_data.points_used);
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL newton_divided_difference_interp_core");
            $finish;
        end
    end

    // End of run: all beats in, all results out, then a short drain.
    initial begin
        beats_taken  = 0;
        results_seen = 0;
        mismatches   = 0;
        cycle_count  = 0;
        pt_count     = 0;
        pt_dropped   = 1'b0;
        wait (stim_done);
        wait (pending_results.size() == 0);
        repeat (200) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("PASS newton_divided_difference_interp_core");
        end else begin
            $display("FAIL newton_divided_difference_interp_core");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/ndd_pkg.sv
hdl/newton_divided_difference_interp_core.sv
tb/newton_divided_difference_interp_core_tb.sv
